[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define QVR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Concurrent assertion that is also checked while reset is asserted.
`define QVR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

[hw/rtl/qvr_pkg.sv]
// Package with constants and helper functions for the quaternion vector rotator.
package qvr_pkg;

	// Default widths of the quaternion and vector inputs.
	localparam int DEF_QUAT_WIDTH = 16;
	localparam int DEF_VEC_WIDTH  = 16;

	// Quaternion component lanes.
	localparam int QX = 0;
	localparam int QY = 1;
	localparam int QZ = 2;
	localparam int QW = 3;
	localparam int NUM_QUAT = 4;
	localparam int NUM_VEC  = 3;

	// Normalization: magnitudes are aligned so the largest lies in [2^29, 2^30).
	localparam int NORM_BITS   = 30;
	localparam int SQ_BITS     = 2 * NORM_BITS;
	localparam int SUM_BITS    = SQ_BITS + 2;
	localparam int ROOT_BITS   = SUM_BITS / 2;
	localparam int SQRT_STEPS  = ROOT_BITS;

	// Division for the Q1.15 components: quotient below 2^16.
	localparam int FRAC_SHIFT  = 16;
	localparam int DIV_STEPS   = 16;
	localparam int NUM_BITS    = NORM_BITS + FRAC_SHIFT + 1;
	localparam int DEN_BITS    = ROOT_BITS + 1;

	// Normalized component format: signed, -32768..32768.
	localparam int QN_BITS     = 17;
	localparam int ONE_Q15     = 32768;

	// Rotation matrix arithmetic.
	localparam int PROD_BITS   = 2 * QN_BITS;
	localparam int MAT_BITS    = PROD_BITS + 2;
	localparam int ROUND_SHIFT = 30;
	localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);

	// Result format.
	localparam int OUT_BITS    = 17;
	localparam int OUT_LIMIT   = 56756;

	// Index of the most significant set bit of a word, zero for zero.
	function automatic logic [4:0] msb_pos(input logic [31:0] val);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (val[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

endpackage

[hw/rtl/quaternion_vector_rotate.sv]
// An accepted input transaction passes the normalize pipeline, then the rotate pipeline.
// Throughput: one transaction per cycle unless stalled; square root and division set the depth.
// A stalled result freezes the whole pipeline, so no transaction is lost or repeated.
// Reset (arst_n low) clears all valid bits at once; data registers are not reset.
module quaternion_vector_rotate import qvr_pkg::*; #(
	parameter int QUAT_WIDTH = DEF_QUAT_WIDTH,
	parameter int VEC_WIDTH  = DEF_VEC_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [QUAT_WIDTH-1:0] quat_x,
	input  logic signed [QUAT_WIDTH-1:0] quat_y,
	input  logic signed [QUAT_WIDTH-1:0] quat_z,
	input  logic signed [QUAT_WIDTH-1:0] quat_w,
	input  logic signed [VEC_WIDTH-1:0]  vec_x,
	input  logic signed [VEC_WIDTH-1:0]  vec_y,
	input  logic signed [VEC_WIDTH-1:0]  vec_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [OUT_BITS-1:0]   rot_x,
	output logic signed [OUT_BITS-1:0]   rot_y,
	output logic signed [OUT_BITS-1:0]   rot_z,
	output logic                         used_identity
);

	logic                         en;
	logic signed [QUAT_WIDTH-1:0] quat [NUM_QUAT];
	logic signed [VEC_WIDTH-1:0]  vec [NUM_VEC];
	logic                         nrm_valid;
	logic signed [QN_BITS-1:0]    qn [NUM_QUAT];
	logic signed [VEC_WIDTH-1:0]  nrm_vec [NUM_VEC];
	logic                         nrm_ident;
	logic signed [OUT_BITS-1:0]   rot [NUM_VEC];

	// The pipeline advances unless a finished result is held by the receiver.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign quat[QX] = quat_x;
	assign quat[QY] = quat_y;
	assign quat[QZ] = quat_z;
	assign quat[QW] = quat_w;
	assign vec[0]   = vec_x;
	assign vec[1]   = vec_y;
	assign vec[2]   = vec_z;

	// Quaternion normalization.
	qvr_norm #(
		.QUAT_WIDTH (QUAT_WIDTH),
		.VEC_WIDTH  (VEC_WIDTH)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.quat      (quat),
		.vec       (vec),
		.out_valid (nrm_valid),
		.qn        (qn),
		.vec_out   (nrm_vec),
		.ident     (nrm_ident)
	);

	// Vector rotation.
	qvr_rotate #(
		.VEC_WIDTH (VEC_WIDTH)
	) u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (nrm_valid),
		.qn        (qn),
		.vec       (nrm_vec),
		.ident     (nrm_ident),
		.out_valid (out_valid),
		.rot       (rot),
		.ident_out (used_identity)
	);

	assign rot_x = rot[0];
	assign rot_y = rot[1];
	assign rot_z = rot[2];

endmodule

[hw/rtl/qvr_norm.sv]
// Pipelined quaternion normalizer: alignment, sum of squares, square root, division.
module qvr_norm import qvr_pkg::*; #(
	parameter int QUAT_WIDTH = DEF_QUAT_WIDTH,
	parameter int VEC_WIDTH  = DEF_VEC_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [QUAT_WIDTH-1:0] quat [NUM_QUAT],
	input  logic signed [VEC_WIDTH-1:0]  vec [NUM_VEC],
	output logic                         out_valid,
	output logic signed [QN_BITS-1:0]    qn [NUM_QUAT],
	output logic signed [VEC_WIDTH-1:0]  vec_out [NUM_VEC],
	output logic                         ident
);

	// Sideband layout: vector, identity flag, signs, aligned magnitudes.
	localparam int IDENT_BIT = NUM_VEC * VEC_WIDTH;
	localparam int NEG_LSB   = IDENT_BIT + 1;
	localparam int NRM_LSB   = NEG_LSB + NUM_QUAT;
	localparam int SBW       = NRM_LSB + NUM_QUAT * NORM_BITS;
	// Five stages up to the sum of squares, then square root, setup, division, signs.
	localparam int LAT       = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

	logic [LAT-1:0] vld_q;

	logic [QUAT_WIDTH-1:0]       mag_s1 [NUM_QUAT];
	logic [NUM_QUAT-1:0]         neg_s1;
	logic signed [VEC_WIDTH-1:0] vec_s1 [NUM_VEC];

	logic [QUAT_WIDTH-1:0]       max_c;
	logic [QUAT_WIDTH-1:0]       mag_s2 [NUM_QUAT];
	logic [QUAT_WIDTH-1:0]       max_s2;
	logic [NUM_QUAT-1:0]         neg_s2;
	logic signed [VEC_WIDTH-1:0] vec_s2 [NUM_VEC];

	logic [4:0]                          pos_c;
	logic [QUAT_WIDTH+NORM_BITS-2:0]     wide_c [NUM_QUAT];
	logic [SBW-1:0]                      sb_s3;

	logic [SQ_BITS-1:0]  sq_s4 [NUM_QUAT];
	logic [SBW-1:0]      sb_s4;

	logic [SUM_BITS-1:0] sqrt_rem_s  [SQRT_STEPS+1];
	logic [SUM_BITS-1:0] sqrt_root_s [SQRT_STEPS+1];
	logic [SBW-1:0]      sqrt_sb_s   [SQRT_STEPS+1];

	logic [ROOT_BITS-1:0] len_c;
	logic [NUM_BITS-1:0]  div_rem_s [DIV_STEPS+1][NUM_QUAT];
	logic [DIV_STEPS-1:0] div_quo_s [DIV_STEPS+1][NUM_QUAT];
	logic [DEN_BITS-1:0]  div_den_s [DIV_STEPS+1];
	logic [SBW-1:0]       div_sb_s  [DIV_STEPS+1];

	logic [SBW-1:0]       sb_fin_c;

	// Valid bits travel alongside the data and advance with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[LAT-1];

	// Stage 1: magnitudes and signs of the quaternion components.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_QUAT; i++) begin
				neg_s1[i] <= quat[i][QUAT_WIDTH-1];
				mag_s1[i] <= quat[i][QUAT_WIDTH-1] ? $unsigned(-quat[i]) : $unsigned(quat[i]);
			end
			for (int i = 0; i < NUM_VEC; i++) begin
				vec_s1[i] <= vec[i];
			end
		end
	end

	// Stage 2: largest magnitude.
	always_comb begin
		max_c = mag_s1[0];
		for (int i = 1; i < NUM_QUAT; i++) begin
			if (mag_s1[i] > max_c) begin
				max_c = mag_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_s1;
			max_s2 <= max_c;
			neg_s2 <= neg_s1;
			vec_s2 <= vec_s1;
		end
	end

	// Stage 3: common shift that puts the largest magnitude in [2^29, 2^30).
	assign pos_c = msb_pos(32'(max_s2));

	always_comb begin
		for (int i = 0; i < NUM_QUAT; i++) begin
			wide_c[i] = {mag_s2[i], {(NORM_BITS-1){1'b0}}} >> pos_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_QUAT; i++) begin
				sb_s3[NRM_LSB + i*NORM_BITS +: NORM_BITS] <= wide_c[i][NORM_BITS-1:0];
			end
			sb_s3[NEG_LSB +: NUM_QUAT] <= neg_s2;
			sb_s3[IDENT_BIT] <= (max_s2 == '0);
			for (int i = 0; i < NUM_VEC; i++) begin
				sb_s3[i*VEC_WIDTH +: VEC_WIDTH] <= vec_s2[i];
			end
		end
	end

	// Stage 4: squares of the aligned magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_QUAT; i++) begin
				sq_s4[i] <= SQ_BITS'(sb_s3[NRM_LSB + i*NORM_BITS +: NORM_BITS])
					* SQ_BITS'(sb_s3[NRM_LSB + i*NORM_BITS +: NORM_BITS]);
			end
			sb_s4 <= sb_s3;
		end
	end

	// Stage 5: sum of squares, which seeds the square root pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			sqrt_rem_s[0]  <= SUM_BITS'(sq_s4[0]) + SUM_BITS'(sq_s4[1])
				+ SUM_BITS'(sq_s4[2]) + SUM_BITS'(sq_s4[3]);
			sqrt_root_s[0] <= '0;
			sqrt_sb_s[0]   <= sb_s4;
		end
	end

	// Square root, one result bit per stage.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SUM_BITS-1:0] BITV =
			{{(SUM_BITS-1){1'b0}}, 1'b1} << (2 * (SQRT_STEPS - 1 - k));
		logic [SUM_BITS-1:0] trial_c;

		assign trial_c = sqrt_root_s[k] + BITV;

		always_ff @(posedge clk) begin
			if (en) begin
				if (sqrt_rem_s[k] >= trial_c) begin
					sqrt_rem_s[k+1]  <= sqrt_rem_s[k] - trial_c;
					sqrt_root_s[k+1] <= (sqrt_root_s[k] >> 1) + BITV;
				end else begin
					sqrt_rem_s[k+1]  <= sqrt_rem_s[k];
					sqrt_root_s[k+1] <= sqrt_root_s[k] >> 1;
				end
				sqrt_sb_s[k+1] <= sqrt_sb_s[k];
			end
		end
	end

	// Division setup: numerator mag*2^16 + len, denominator 2*len.
	assign len_c = sqrt_root_s[SQRT_STEPS][ROOT_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_QUAT; i++) begin
				div_rem_s[0][i] <= NUM_BITS'({sqrt_sb_s[SQRT_STEPS][NRM_LSB + i*NORM_BITS +: NORM_BITS],
					{FRAC_SHIFT{1'b0}}}) + NUM_BITS'(len_c);
				div_quo_s[0][i] <= '0;
			end
			div_den_s[0] <= {len_c, 1'b0};
			div_sb_s[0]  <= sqrt_sb_s[SQRT_STEPS];
		end
	end

	// Restoring division, one quotient bit per stage for all four lanes.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [NUM_BITS-1:0] sub_c;

		assign sub_c = NUM_BITS'(div_den_s[j]) << (DIV_STEPS - 1 - j);

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < NUM_QUAT; i++) begin
					if (div_rem_s[j][i] >= sub_c) begin
						div_rem_s[j+1][i] <= div_rem_s[j][i] - sub_c;
						div_quo_s[j+1][i] <= {div_quo_s[j][i][DIV_STEPS-2:0], 1'b1};
					end else begin
						div_rem_s[j+1][i] <= div_rem_s[j][i];
						div_quo_s[j+1][i] <= {div_quo_s[j][i][DIV_STEPS-2:0], 1'b0};
					end
				end
				div_den_s[j+1] <= div_den_s[j];
				div_sb_s[j+1]  <= div_sb_s[j];
			end
		end
	end

	// Final stage: apply signs, or the identity for a zero quaternion.
	assign sb_fin_c = div_sb_s[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_QUAT; i++) begin
				if (sb_fin_c[IDENT_BIT]) begin
					qn[i] <= (i == QW) ? QN_BITS'(ONE_Q15) : '0;
				end else if (sb_fin_c[NEG_LSB + i]) begin
					qn[i] <= -$signed({1'b0, div_quo_s[DIV_STEPS][i]});
				end else begin
					qn[i] <= $signed({1'b0, div_quo_s[DIV_STEPS][i]});
				end
			end
			for (int i = 0; i < NUM_VEC; i++) begin
				vec_out[i] <= sb_fin_c[i*VEC_WIDTH +: VEC_WIDTH];
			end
			ident <= sb_fin_c[IDENT_BIT];
		end
	end

endmodule

[hw/rtl/qvr_rotate.sv]
// Pipelined rotation of a vector by a normalized quaternion through its rotation matrix.
module qvr_rotate import qvr_pkg::*; #(
	parameter int VEC_WIDTH = DEF_VEC_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [QN_BITS-1:0]   qn [NUM_QUAT],
	input  logic signed [VEC_WIDTH-1:0] vec [NUM_VEC],
	input  logic                        ident,
	output logic                        out_valid,
	output logic signed [OUT_BITS-1:0]  rot [NUM_VEC],
	output logic                        ident_out
);

	localparam int STAGES = 5;
	localparam int MVW    = MAT_BITS + VEC_WIDTH;
	localparam int ACW    = MVW + 2;

	// Product slots.
	localparam int P_XX = 0;
	localparam int P_YY = 1;
	localparam int P_ZZ = 2;
	localparam int P_WW = 3;
	localparam int P_XY = 4;
	localparam int P_XZ = 5;
	localparam int P_YZ = 6;
	localparam int P_WX = 7;
	localparam int P_WY = 8;
	localparam int P_WZ = 9;
	localparam int NUM_PROD = 10;

	logic [STAGES-1:0] vld_q;

	logic signed [PROD_BITS-1:0] p_s1 [NUM_PROD];
	logic signed [VEC_WIDTH-1:0] vec_s1 [NUM_VEC];
	logic signed [VEC_WIDTH-1:0] vec_s2 [NUM_VEC];
	logic signed [MAT_BITS-1:0]  m_s2 [NUM_VEC*NUM_VEC];
	logic signed [MVW-1:0]       mv_s3 [NUM_VEC*NUM_VEC];
	logic signed [ACW-1:0]       acc_s4 [NUM_VEC];
	logic [STAGES-1:0]           ident_q;

	logic [ACW-1:0]      mag_c [NUM_VEC];
	logic [ACW-1:0]      rnd_c [NUM_VEC];
	logic [OUT_BITS-1:0] sat_c [NUM_VEC];

	// Valid bits and the identity flag follow the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ident_q <= {ident_q[STAGES-2:0], ident};
		end
	end

	assign out_valid = vld_q[STAGES-1];
	assign ident_out = ident_q[STAGES-1];

	// Stage 1: the ten component products.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[P_XX] <= qn[QX] * qn[QX];
			p_s1[P_YY] <= qn[QY] * qn[QY];
			p_s1[P_ZZ] <= qn[QZ] * qn[QZ];
			p_s1[P_WW] <= qn[QW] * qn[QW];
			p_s1[P_XY] <= qn[QX] * qn[QY];
			p_s1[P_XZ] <= qn[QX] * qn[QZ];
			p_s1[P_YZ] <= qn[QY] * qn[QZ];
			p_s1[P_WX] <= qn[QW] * qn[QX];
			p_s1[P_WY] <= qn[QW] * qn[QY];
			p_s1[P_WZ] <= qn[QW] * qn[QZ];
			vec_s1 <= vec;
		end
	end

	// Stage 2: rotation matrix entries in Q2.30.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2[0] <= MAT_BITS'(p_s1[P_WW]) + MAT_BITS'(p_s1[P_XX])
				- MAT_BITS'(p_s1[P_YY]) - MAT_BITS'(p_s1[P_ZZ]);
			m_s2[1] <= (MAT_BITS'(p_s1[P_XY]) - MAT_BITS'(p_s1[P_WZ])) <<< 1;
			m_s2[2] <= (MAT_BITS'(p_s1[P_XZ]) + MAT_BITS'(p_s1[P_WY])) <<< 1;
			m_s2[3] <= (MAT_BITS'(p_s1[P_XY]) + MAT_BITS'(p_s1[P_WZ])) <<< 1;
			m_s2[4] <= MAT_BITS'(p_s1[P_WW]) - MAT_BITS'(p_s1[P_XX])
				+ MAT_BITS'(p_s1[P_YY]) - MAT_BITS'(p_s1[P_ZZ]);
			m_s2[5] <= (MAT_BITS'(p_s1[P_YZ]) - MAT_BITS'(p_s1[P_WX])) <<< 1;
			m_s2[6] <= (MAT_BITS'(p_s1[P_XZ]) - MAT_BITS'(p_s1[P_WY])) <<< 1;
			m_s2[7] <= (MAT_BITS'(p_s1[P_YZ]) + MAT_BITS'(p_s1[P_WX])) <<< 1;
			m_s2[8] <= MAT_BITS'(p_s1[P_WW]) - MAT_BITS'(p_s1[P_XX])
				- MAT_BITS'(p_s1[P_YY]) + MAT_BITS'(p_s1[P_ZZ]);
			vec_s2 <= vec_s1;
		end
	end

	// Stage 3: matrix entries times vector components.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < NUM_VEC; r++) begin
				for (int c = 0; c < NUM_VEC; c++) begin
					mv_s3[r*NUM_VEC + c] <= MVW'(m_s2[r*NUM_VEC + c]) * MVW'(vec_s2[c]);
				end
			end
		end
	end

	// Stage 4: row sums.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < NUM_VEC; r++) begin
				acc_s4[r] <= ACW'(mv_s3[r*NUM_VEC]) + ACW'(mv_s3[r*NUM_VEC + 1])
					+ ACW'(mv_s3[r*NUM_VEC + 2]);
			end
		end
	end

	// Stage 5: round half away from zero, then saturate.
	always_comb begin
		for (int r = 0; r < NUM_VEC; r++) begin
			mag_c[r] = acc_s4[r][ACW-1] ? $unsigned(-acc_s4[r]) : $unsigned(acc_s4[r]);
			rnd_c[r] = (mag_c[r] + ACW'(ROUND_HALF)) >> ROUND_SHIFT;
			sat_c[r] = (rnd_c[r] > ACW'(OUT_LIMIT)) ? OUT_BITS'(OUT_LIMIT)
				: rnd_c[r][OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < NUM_VEC; r++) begin
				rot[r] <= acc_s4[r][ACW-1] ? -$signed(sat_c[r]) : $signed(sat_c[r]);
			end
		end
	end

endmodule

[hw/rtl/qvr_checker.sv]
// Port-level checker for the quaternion vector rotator and its bind statement.
`include "assert_macros.svh"

module qvr_checker import qvr_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [OUT_BITS-1:0] rot_x,
	input logic signed [OUT_BITS-1:0] rot_y,
	input logic signed [OUT_BITS-1:0] rot_z,
	input logic                       used_identity
);

	// No result is offered while reset is held.
	`QVR_ASSERT_ALWAYS(a_reset_no_out, clk, !arst_n |-> !out_valid)

	// The input side is only held off while a result waits on the receiver.
	`QVR_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid && out_stall))

	// Every result lies within the saturation limits.
	`QVR_ASSERT(a_rot_range, clk, arst_n, out_valid |-> (rot_x >= -OUT_LIMIT && rot_x <= OUT_LIMIT && rot_y >= -OUT_LIMIT && rot_y <= OUT_LIMIT && rot_z >= -OUT_LIMIT && rot_z <= OUT_LIMIT))

	// A stalled result transaction holds its payload.
	`QVR_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(rot_x) && $stable(rot_y) && $stable(rot_z) && $stable(used_identity)))

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.rot_x         (rot_x),
	.rot_y         (rot_y),
	.rot_z         (rot_z),
	.used_identity (used_identity)
);

[test/quaternion_vector_rotate_checker.sv]
// Checker that predicts each rotation result and compares it with the block's output.
module quaternion_vector_rotate_checker import qvr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic signed [15:0]         quat_x,
	input  logic signed [15:0]         quat_y,
	input  logic signed [15:0]         quat_z,
	input  logic signed [15:0]         quat_w,
	input  logic signed [15:0]         vec_x,
	input  logic signed [15:0]         vec_y,
	input  logic signed [15:0]         vec_z,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [OUT_BITS-1:0] rot_x,
	input  logic signed [OUT_BITS-1:0] rot_y,
	input  logic signed [OUT_BITS-1:0] rot_z,
	input  logic                       used_identity,
	output int                         errors,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] x;
		logic signed [OUT_BITS-1:0] y;
		logic signed [OUT_BITS-1:0] z;
		logic                       ident;
	} rotation_t;

	rotation_t rotations_due[$];

	// Integer square root, floor.
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Round a Q2.30 accumulator to nearest, ties away from zero, then clamp.
	function automatic logic signed [OUT_BITS-1:0] round_clamp(input longint acc);
		longint unsigned mag, r;
		mag = acc < 0 ? longint'(-acc) : acc;
		r = (mag + (64'd1 << 29)) >> 30;
		if (r > OUT_LIMIT) r = OUT_LIMIT;
		return acc < 0 ? -OUT_BITS'(r) : OUT_BITS'(r);
	endfunction

	// Normalize the quaternion and rotate the vector.
	function automatic rotation_t predict_rotation(input longint c[4], input longint v[3]);
		longint unsigned mag[4], big, sum, len, r;
		longint q[4], m[3][3], acc;
		longint x, y, z, w;
		int up, down;
		rotation_t res;
		big = 0;
		up = 0;
		down = 0;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = c[i] < 0 ? -c[i] : c[i];
			if (mag[i] > big) big = mag[i];
		end
		res.ident = (big == 0);
		if (res.ident) begin
			q = '{0, 0, 0, ONE_Q15};
		end else begin
			while (big < (64'd1 << 29)) begin big <<= 1; up++; end
			while (big >= (64'd1 << 30)) begin big >>= 1; down++; end
			for (int i = 0; i < 4; i++) begin
				mag[i] = (mag[i] << up) >> down;
				sum += mag[i] * mag[i];
			end
			len = int_sqrt(sum);
			for (int i = 0; i < 4; i++) begin
				r = ((mag[i] << 16) + len) / (2 * len);
				q[i] = c[i] < 0 ? -longint'(r) : longint'(r);
			end
		end
		x = q[QX]; y = q[QY]; z = q[QZ]; w = q[QW];
		m[0] = '{w*w + x*x - y*y - z*z, 2*(x*y - w*z), 2*(x*z + w*y)};
		m[1] = '{2*(x*y + w*z), w*w - x*x + y*y - z*z, 2*(y*z - w*x)};
		m[2] = '{2*(x*z - w*y), 2*(y*z + w*x), w*w - x*x - y*y + z*z};
		acc = m[0][0]*v[0] + m[0][1]*v[1] + m[0][2]*v[2];
		res.x = round_clamp(acc);
		acc = m[1][0]*v[0] + m[1][1]*v[1] + m[1][2]*v[2];
		res.y = round_clamp(acc);
		acc = m[2][0]*v[0] + m[2][1]*v[1] + m[2][2]*v[2];
		res.z = round_clamp(acc);
		return res;
	endfunction

	assign pending = rotations_due.size();

	// Queue a prediction for each input transaction and check each output transaction.
	always @(posedge clk or negedge arst_n) begin
		rotation_t exp_rot;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				rotations_due.push_back(predict_rotation(
					'{quat_x, quat_y, quat_z, quat_w}, '{vec_x, vec_y, vec_z}));
			end
			if (out_valid && !out_stall) begin
				if (rotations_due.size() == 0) begin
					$display("%t: unexpected result %0d %0d %0d %0d", $time,
						rot_x, rot_y, rot_z, used_identity);
					errors <= errors + 1;
				end else begin
					exp_rot = rotations_due.pop_front();
					if (exp_rot != {rot_x, rot_y, rot_z, used_identity}) begin
						$display("%t: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
							$time, exp_rot.x, exp_rot.y, exp_rot.z, exp_rot.ident,
							rot_x, rot_y, rot_z, used_identity);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

[test/quaternion_vector_rotate_tb.sv]
// Testbench top: drives rotation transactions with random gaps and stalls, gives the verdict.
module quaternion_vector_rotate_tb import qvr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ITEMS = 450;
	localparam int IDLE_LIMIT = 5000;

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall, used_identity;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z;
	logic signed [OUT_BITS-1:0] rot_x, rot_y, rot_z;
	int errors, pending, idle_cycles;
	bit hold_off;

	quaternion_vector_rotate DUT (.*);
	quaternion_vector_rotate_checker checker_i (.*);

	// Clock.
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Pick a component: mostly random, sometimes an extreme or a small value.
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 6)) - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one transaction and hold it until accepted.
	task automatic send_rotation(input logic [15:0] qx, qy, qz, qw, vx, vy, vz);
		in_valid <= 1;
		{quat_x, quat_y, quat_z, quat_w} <= {qx, qy, qz, qw};
		{vec_x, vec_y, vec_z} <= {vx, vy, vz};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Receiver stall pattern, with one long hold-off.
	initial begin
		int phase;
		out_stall = 1;
		@(posedge arst_n);
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if (hold_off) out_stall <= 1;
			else if (phase % 300 < 100) out_stall <= 0;
			else out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog on cycles with no accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		logic [15:0] v[7];
		int burst;
		{in_valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z} = '0;
		hold_off = 0;
		idle_cycles = 0;
		// Reset goes low after time zero so that every flop sees the falling edge.
		arst_n = 1;
		#1 arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: identity cases, zero quaternion, extremes and saturation.
		send_rotation(0, 0, 0, 0, 16'h7fff, 16'h8000, 16'h1234);
		send_rotation(0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
		send_rotation(0, 0, 0, 1, 16'h7fff, 16'h8000, 0);
		send_rotation(16'h8000, 0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
		send_rotation(0, 16'h8000, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
		send_rotation(0, 0, 16'h7fff, 0, 16'h7fff, 16'h8000, 16'h7fff);
		send_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_rotation(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_rotation(1, 1, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff);
		send_rotation(0, 1, 1, 0, 16'h8000, 16'h8000, 16'h8000);
		send_rotation(1, 0, 1, 0, 16'h7fff, 16'h8000, 16'h7fff);
		send_rotation(1, 2, 3, 4, 100, -200, 300);
		send_rotation(-1, -1, -1, -1, 16'h7fff, 16'h7fff, 16'h8000);
		send_rotation(3, 0, 0, 4, 1, 1, 1);
		send_rotation(16'hffff, 0, 0, 0, 16'hffff, 0, 1);
		in_valid <= 0;
		@(posedge clk);

		// Long receiver hold-off while the sender keeps offering transactions.
		fork
			begin
				hold_off = 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			repeat (80) begin
				foreach (v[i]) v[i] = pick_value();
				send_rotation(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
			end
		join
		in_valid <= 0;
		@(posedge clk);

		// Random bursts with random gaps.
		for (int n = 0; n < NUM_ITEMS - 95; ) begin
			burst = $urandom_range(1, 20);
			repeat (burst) begin
				foreach (v[i]) v[i] = pick_value();
				send_rotation(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
				n++;
			end
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 0;

		// Drain.
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
